/* sv/ctr_pkg.sv */
// Package of the CAN transport receiver: field widths, codes, the command and result
// records and the helpers that build clear-to-send and end-of-message frames.
// Depends on nothing; every other file of the block imports it.
package ctr_pkg;

	// Field widths of the channels.
	localparam int OP_W       = 2;
	localparam int ID_W       = 29;
	localparam int DATA_W     = 64;
	localparam int OFFS_W     = 11;
	localparam int PBYTES_W   = 56;
	localparam int CNT_W      = 3;
	localparam int PGN_W      = 24;
	localparam int LEN_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Default depth of the command queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Operation codes of an input transaction.
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_CONN = 2'd1;
	localparam logic [OP_W-1:0] OP_DATA = 2'd2;

	// Control bytes of connection management frames.
	localparam logic [7:0] CB_RTS = 8'd16;
	localparam logic [7:0] CB_CTS = 8'd17;
	localparam logic [7:0] CB_EOM = 8'd19;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	// Bytes carried by one data packet.
	localparam int PKT_BYTES = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CTS_WINDOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTS_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT = 2'd2;

	// Register reset values.
	localparam logic [7:0]  CTS_WINDOW_RST   = 8'd8;
	localparam logic [15:0] CTS_TIMEOUT_RST  = 16'd125;
	localparam logic [15:0] DATA_TIMEOUT_RST = 16'd75;

	// Commands handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_RTS  = 2'd1,
		CMD_DATA = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ID_W-1:0]    can_id;
		logic [LEN_W-1:0]   msg_len;
		logic [7:0]         packets;
		logic [PGN_W-1:0]   pgn;
		logic [7:0]         seq;
		logic [PBYTES_W-1:0] data;
	} cmd_t;

	// Kinds of result transaction.
	typedef enum logic [1:0] {
		RK_FRAME   = 2'd0,
		RK_PAYLOAD = 2'd1,
		RK_DONE    = 2'd2,
		RK_ABORT   = 2'd3
	} result_kind_t;

	typedef struct packed {
		result_kind_t         kind;
		logic [ID_W-1:0]      tx_can_id;
		logic [DATA_W-1:0]    tx_data;
		logic [OFFS_W-1:0]    payload_offset;
		logic [PBYTES_W-1:0]  payload_bytes;
		logic [CNT_W-1:0]     payload_count;
		logic [PGN_W-1:0]     pgn;
		logic [LEN_W-1:0]     message_length;
		logic                 last_result;
	} result_t;

	// Peer identifier with its source and destination bytes exchanged.
	function automatic logic [ID_W-1:0] swap_id(input logic [ID_W-1:0] id);
		swap_id = {id[ID_W-1:16], id[7:0], id[15:8]};
	endfunction

	// Clear-to-send frame bytes.
	function automatic logic [DATA_W-1:0] cts_frame(input logic [7:0] count,
			input logic [7:0] start, input logic [PGN_W-1:0] pgn);
		cts_frame = {pgn, FILL_BYTE, FILL_BYTE, start, count, CB_CTS};
	endfunction

	// End-of-message acknowledge frame bytes.
	function automatic logic [DATA_W-1:0] eom_frame(input logic [LEN_W-1:0] len,
			input logic [7:0] packets, input logic [PGN_W-1:0] pgn);
		eom_frame = {pgn, FILL_BYTE, packets, 5'd0, len[10:8], len[7:0], CB_EOM};
	endfunction

endpackage

/* sv/ctr_if.sv */
// Channel interfaces of the CAN transport receiver: input frames, results and
// configuration writes. Depends on ctr_pkg for the field widths.

interface ctr_in_if import ctr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     can_id;
	logic [DATA_W-1:0]   frame_data;

	modport source(output valid, operation, can_id, frame_data, input ready);
	modport sink(input valid, operation, can_id, frame_data, output ready);
endinterface

interface ctr_out_if import ctr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          result_kind;
	logic [ID_W-1:0]     tx_can_id;
	logic [DATA_W-1:0]   tx_data;
	logic [OFFS_W-1:0]   payload_offset;
	logic [PBYTES_W-1:0] payload_bytes;
	logic [CNT_W-1:0]    payload_count;
	logic [PGN_W-1:0]    pgn;
	logic [LEN_W-1:0]    message_length;
	logic                last_result;

	modport source(output valid, result_kind, tx_can_id, tx_data, payload_offset,
		payload_bytes, payload_count, pgn, message_length, last_result, input ready);
	modport sink(input valid, result_kind, tx_can_id, tx_data, payload_offset,
		payload_bytes, payload_count, pgn, message_length, last_result, output ready);
endinterface

interface ctr_cfg_if import ctr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/ctr_front.sv */
// Front of the CAN transport receiver: accepts input transactions, checks
// request-to-send frames and drops frames that can never have an effect.
// Depends on ctr_pkg and ctr_in_if.
module ctr_front import ctr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ctr_in_if.sink   rx,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	cmd_t        cmd_d;
	logic        keep;
	logic [15:0] rts_len;
	logic [7:0]  rts_pk;
	logic [10:0] rts_pk7;
	logic        rts_ok;

	// A request-to-send is sound when its packet count is ceil(length / 7).
	assign rts_len = rx.frame_data[23:8];
	assign rts_pk  = rx.frame_data[31:24];
	assign rts_pk7 = {3'd0, rts_pk} * 11'(PKT_BYTES);
	assign rts_ok  = (rts_len != 16'd0) && ({5'd0, rts_pk7} >= rts_len)
		&& (({1'b0, rts_len} + 17'd6) >= {6'd0, rts_pk7});

	// Classify the frame into a command for the back.
	always_comb begin
		cmd_d.can_id  = rx.can_id;
		cmd_d.msg_len = rts_len[LEN_W-1:0];
		cmd_d.packets = rts_pk;
		cmd_d.pgn     = rx.frame_data[63:40];
		cmd_d.seq     = rx.frame_data[7:0];
		cmd_d.data    = rx.frame_data[63:8];
		cmd_d.kind    = CMD_TICK;
		keep          = 1'b0;
		case (rx.operation)
			OP_TICK: begin
				keep = 1'b1;
			end
			OP_CONN: begin
				cmd_d.kind = CMD_RTS;
				keep       = (rx.frame_data[7:0] == CB_RTS) && rts_ok;
			end
			OP_DATA: begin
				cmd_d.kind = CMD_DATA;
				keep       = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Holding register between the input channel and the command queue.
	assign rx.ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* sv/ctr_fifo.sv */
// Command queue between the front and the back of the CAN transport receiver,
// so that each side stalls on its own. Depends on ctr_pkg for the command record.
module ctr_fifo import ctr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != FILL_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* sv/ctr_back.sv */
// Back of the CAN transport receiver: session state, configuration registers and
// the result buffer that hands out up to three results per command.
// Depends on ctr_pkg, ctr_out_if and ctr_cfg_if.
module ctr_back import ctr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	ctr_cfg_if.sink   cfg,
	ctr_out_if.source result
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WAIT = 3'b010,
		PH_RECV = 3'b100
	} phase_t;

	// Configuration registers.
	logic [7:0]  cts_window_q;
	logic [15:0] cts_timeout_q;
	logic [15:0] data_timeout_q;

	// Session state.
	phase_t            phase_q, phase_d;
	logic [ID_W-1:0]   peer_id_q, peer_id_d;
	logic [LEN_W-1:0]  total_length_q, total_length_d;
	logic [7:0]        total_packets_q, total_packets_d;
	logic [PGN_W-1:0]  group_number_q, group_number_d;
	logic [7:0]        win_start_q, win_start_d;
	logic [7:0]        win_size_q, win_size_d;
	logic [7:0]        win_recv_q, win_recv_d;
	logic [15:0]       tick_count_q, tick_count_d;

	// Result buffer.
	result_t     res_q [3];
	result_t     res_d [3];
	logic [1:0]  res_n_q, res_n_d;
	logic [1:0]  res_idx_q;
	logic        busy_q;
	logic        last_slot;
	logic        pop;

	// Working values.
	logic [7:0]  win_eff;
	logic [7:0]  expect_seq;
	logic [8:0]  recv_inc;
	logic        last_pkt;
	logic [11:0] tail_len;
	logic [CNT_W-1:0] cnt;
	logic [PBYTES_W-1:0] pbytes;
	logic [OFFS_W-1:0] offset;
	logic [8:0]  win_end;
	logic [7:0]  rem_pk;
	logic [7:0]  next_start;
	logic [15:0] limit;

	assign cfg.ready = 1'b1;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cts_window_q   <= CTS_WINDOW_RST;
			cts_timeout_q  <= CTS_TIMEOUT_RST;
			data_timeout_q <= DATA_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CTS_WINDOW:   cts_window_q   <= cfg.data[7:0];
				CFG_CTS_TIMEOUT:  cts_timeout_q  <= cfg.data;
				CFG_DATA_TIMEOUT: data_timeout_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// A command is taken when the buffer is empty or its last result leaves now.
	assign last_slot = res_idx_q == (res_n_q - 2'd1);
	assign cmd_ready = !busy_q || (result.ready && last_slot);
	assign pop       = cmd_valid && cmd_ready;

	// Shared arithmetic for data packets, the window size and the tick limit.
	assign win_eff    = (cts_window_q == 8'd0) ? 8'd1 : cts_window_q;
	assign expect_seq = win_start_q + win_recv_q;
	assign recv_inc   = {1'b0, win_recv_q} + 9'd1;
	assign last_pkt   = expect_seq >= total_packets_q;
	assign tail_len   = {1'b0, total_length_q}
		- ({4'd0, total_packets_q - 8'd1} * 12'(PKT_BYTES));
	assign cnt        = (!last_pkt || (tail_len > 12'(PKT_BYTES))) ? CNT_W'(PKT_BYTES)
		: tail_len[CNT_W-1:0];
	assign offset     = ({3'd0, expect_seq} - 11'd1) * 11'(PKT_BYTES);
	assign win_end    = {1'b0, win_start_q} + {1'b0, win_size_q} - 9'd1;
	assign rem_pk     = total_packets_q - win_end[7:0];
	assign next_start = win_end[7:0] + 8'd1;
	assign limit      = (phase_q == PH_WAIT) ? cts_timeout_q : data_timeout_q;

	// Payload bytes beyond the packet's count read as zero.
	always_comb begin
		for (int i = 0; i < PKT_BYTES; i++) begin
			pbytes[i*8 +: 8] = (CNT_W'(i) < cnt) ? cmd.data[i*8 +: 8] : 8'd0;
		end
	end

	// Execute one command: next session state and its results.
	always_comb begin
		phase_d         = phase_q;
		peer_id_d       = peer_id_q;
		total_length_d  = total_length_q;
		total_packets_d = total_packets_q;
		group_number_d  = group_number_q;
		win_start_d     = win_start_q;
		win_size_d      = win_size_q;
		win_recv_d      = win_recv_q;
		tick_count_d    = tick_count_q;
		res_n_d         = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
		end

		case (cmd.kind)
			CMD_TICK: begin
				if (phase_q == PH_WAIT || phase_q == PH_RECV) begin
					if (tick_count_q >= limit) begin
						res_d[0].kind = RK_ABORT;
						res_n_d       = 2'd1;
						phase_d       = PH_IDLE;
					end else begin
						tick_count_d = tick_count_q + 16'd1;
					end
				end
			end
			CMD_RTS: begin
				peer_id_d       = cmd.can_id;
				total_length_d  = cmd.msg_len;
				total_packets_d = cmd.packets;
				group_number_d  = cmd.pgn;
				win_start_d     = 8'd1;
				win_size_d      = (cmd.packets < win_eff) ? cmd.packets : win_eff;
				win_recv_d      = 8'd0;
				tick_count_d    = 16'd0;
				phase_d         = PH_WAIT;
				res_d[0].kind      = RK_FRAME;
				res_d[0].tx_can_id = swap_id(cmd.can_id);
				res_d[0].tx_data   = cts_frame(win_size_d, 8'd1, cmd.pgn);
				res_n_d            = 2'd1;
			end
			CMD_DATA: begin
				if (phase_q == PH_WAIT || phase_q == PH_RECV) begin
					if (cmd.seq != expect_seq) begin
						// Out-of-order data aborts only once packets are flowing.
						if (phase_q == PH_RECV) begin
							res_d[0].kind = RK_ABORT;
							res_n_d       = 2'd1;
							phase_d       = PH_IDLE;
						end
					end else begin
						win_recv_d   = recv_inc[7:0];
						tick_count_d = 16'd0;
						phase_d      = PH_RECV;
						res_d[0].kind           = RK_PAYLOAD;
						res_d[0].payload_offset = offset;
						res_d[0].payload_bytes  = pbytes;
						res_d[0].payload_count  = cnt;
						res_n_d                 = 2'd1;
						if (recv_inc >= {1'b0, win_size_q}) begin
							if (win_end >= {1'b0, total_packets_q}) begin
								// Final window complete: report done and acknowledge.
								res_d[1].kind      = RK_DONE;
								res_d[2].kind      = RK_FRAME;
								res_d[2].tx_can_id = swap_id(peer_id_q);
								res_d[2].tx_data   = eom_frame(total_length_q,
									total_packets_q, group_number_q);
								res_n_d            = 2'd3;
								phase_d            = PH_IDLE;
							end else begin
								// Window complete: grant the next one.
								win_start_d = next_start;
								win_size_d  = (rem_pk < win_eff) ? rem_pk : win_eff;
								win_recv_d  = 8'd0;
								phase_d     = PH_WAIT;
								res_d[1].kind      = RK_FRAME;
								res_d[1].tx_can_id = swap_id(peer_id_q);
								res_d[1].tx_data   = cts_frame(win_size_d, next_start,
									group_number_q);
								res_n_d            = 2'd2;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase

		// Session fields and the last-result mark apply to every slot.
		for (int i = 0; i < 3; i++) begin
			res_d[i].pgn            = group_number_d;
			res_d[i].message_length = total_length_d;
			res_d[i].last_result    = 2'(i) == (res_n_d - 2'd1);
		end
	end

	// Session state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			peer_id_q       <= '0;
			total_length_q  <= '0;
			total_packets_q <= '0;
			group_number_q  <= '0;
			win_start_q     <= '0;
			win_size_q      <= '0;
			win_recv_q      <= '0;
			tick_count_q    <= '0;
		end else if (pop) begin
			phase_q         <= phase_d;
			peer_id_q       <= peer_id_d;
			total_length_q  <= total_length_d;
			total_packets_q <= total_packets_d;
			group_number_q  <= group_number_d;
			win_start_q     <= win_start_d;
			win_size_q      <= win_size_d;
			win_recv_q      <= win_recv_d;
			tick_count_q    <= tick_count_d;
		end
	end

	// Result buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			res_n_q   <= '0;
			res_idx_q <= '0;
		end else if (pop) begin
			busy_q    <= res_n_d != 2'd0;
			res_n_q   <= res_n_d;
			res_idx_q <= 2'd0;
		end else if (busy_q && result.ready) begin
			if (last_slot) begin
				busy_q <= 1'b0;
			end else begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	// Result buffer contents.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	// Output channel straight from the buffer registers.
	assign result.valid          = busy_q;
	assign result.result_kind    = res_q[res_idx_q].kind;
	assign result.tx_can_id      = res_q[res_idx_q].tx_can_id;
	assign result.tx_data        = res_q[res_idx_q].tx_data;
	assign result.payload_offset = res_q[res_idx_q].payload_offset;
	assign result.payload_bytes  = res_q[res_idx_q].payload_bytes;
	assign result.payload_count  = res_q[res_idx_q].payload_count;
	assign result.pgn            = res_q[res_idx_q].pgn;
	assign result.message_length = res_q[res_idx_q].message_length;
	assign result.last_result    = res_q[res_idx_q].last_result;

`ifndef ASSERT_OFF
	// The slot being shown always lies inside the filled part of the buffer.
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (res_n_q != 2'd0) && (res_idx_q < res_n_q))
		else $error("result slot outside filled buffer");

	// Only the final slot of a command carries the last-result mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (res_q[res_idx_q].last_result == last_slot))
		else $error("last-result mark on wrong slot");

	// Within a session the window is never already filled.
	a_window_open: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (win_recv_q < win_size_q))
		else $error("window count reached window size in a session");

	// The session phase moves only when a command is executed.
	a_phase_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(phase_q))
		else $error("phase changed without a command");

	// Ticks and data in the idle phase produce no result.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (phase_q == PH_IDLE) && (cmd.kind != CMD_RTS) |=> !busy_q)
		else $error("result produced while idle");
`endif

endmodule

/* sv/can_transport_receiver_top.sv */
// Top level of the CAN transport receiver: front, command queue and back.
// Depends on ctr_pkg, the interfaces in ctr_if and the modules ctr_front,
// ctr_fifo and ctr_back.
//
// Usage: rx_item carries ticks, connection management frames and data frames;
// result carries frames to send (clear-to-send, end-of-message acknowledge),
// payload writes, message-done and abort notices, one per transaction, with
// last_result set on the final result of each input. cfg writes the window
// size and the two timeouts and is always ready; write it while the block is idle.
// Path: an input passes the front holding register and command queue to the back,
// whose result buffer offers its results. Throughput: one input per cycle while each
// input causes at most one result and result.ready is high; the back hands out one
// result per cycle from its buffer while result.ready is high.
// A stalled result channel fills the command queue and then the front holding
// register, after which rx_item.ready falls; nothing is dropped.
// Reset (arst_n low) empties the queue and buffer, returns to idle and loads
// the register defaults; no clearing pass is needed.
module can_transport_receiver_top import ctr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ctr_in_if.sink    rx_item,
	ctr_out_if.source result,
	ctr_cfg_if.sink   cfg
);

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	// Frame acceptance and classification.
	ctr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_item),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// Queue decoupling the front from the back.
	ctr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	// Session execution and result output.
	ctr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

/* test/can_transport_receiver_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of can_transport_receiver_top: sends ticks, connection and data frames,
// predicts each result transaction with a session model of its own and checks them in order.
// Depends on ctr_pkg, the channel interfaces in ctr_if and the RTL of the block.
module can_transport_receiver_top_tb import ctr_pkg::*; ();

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int MAX_REPORTS   = 10;
	localparam int STALL_MAX     = 9;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		SESS_IDLE = 2'd0,
		SESS_WAIT = 2'd1,
		SESS_RECV = 2'd2
	} sess_phase_t;

	logic clk;
	logic arst_n;

	ctr_in_if  rx_if();
	ctr_out_if res_if();
	ctr_cfg_if cfg_if();

	can_transport_receiver_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_item(rx_if),
		.result(res_if),
		.cfg(cfg_if)
	);

	// Register copies as the session model sees them.
	logic [7:0]  cfg_window;
	logic [15:0] cfg_cts_timeout;
	logic [15:0] cfg_data_timeout;

	// Session state of the model.
	sess_phase_t      sess_phase;
	logic [ID_W-1:0]  sess_peer;
	logic [LEN_W-1:0] sess_len;
	logic [PGN_W-1:0] sess_pgn;
	int               sess_packets;
	int               win_first;
	int               win_count;
	int               win_got;
	int               tick_total;

	// Results of the frame being predicted, then the queue of results still awaited.
	result_t step_out[3];
	int      step_n;
	result_t awaited_results[$];

	int failures;
	int counted_items;
	int cycle_count;
	bit src_idle_en;
	bit snk_idle_en;
	int hold_request;
	int snk_stall_left;
	int snk_hold_left;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		logic [31:0] w;
		w = $urandom;
		return w[ID_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] rts_bytes(input logic [15:0] len,
			input logic [7:0] packets, input logic [PGN_W-1:0] pgn, input logic [7:0] extra);
		return {pgn, extra, packets, len, CB_RTS};
	endfunction

	// Peer identifier with destination and source bytes exchanged.
	function automatic logic [ID_W-1:0] peer_reply_id();
		return {sess_peer[ID_W-1:16], sess_peer[7:0], sess_peer[15:8]};
	endfunction

	function automatic logic [DATA_W-1:0] grant_bytes(input int count, input int start);
		logic [7:0] c;
		logic [7:0] s;
		c = count[7:0];
		s = start[7:0];
		return {sess_pgn, FILL_BYTE, FILL_BYTE, s, c, CB_CTS};
	endfunction

	function automatic int effective_window();
		return (cfg_window == 8'd0) ? 1 : int'(cfg_window);
	endfunction

	function automatic void add_result(input result_kind_t kind, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] data, input logic [OFFS_W-1:0] offs,
			input logic [PBYTES_W-1:0] bytes, input logic [CNT_W-1:0] cnt);
		result_t r;
		r.kind           = kind;
		r.tx_can_id      = id;
		r.tx_data        = data;
		r.payload_offset = offs;
		r.payload_bytes  = bytes;
		r.payload_count  = cnt;
		r.pgn            = sess_pgn;
		r.message_length = sess_len;
		r.last_result    = 1'b0;
		step_out[step_n] = r;
		step_n++;
	endfunction

	function automatic void abort_session();
		add_result(RK_ABORT, '0, '0, '0, '0, '0);
		sess_phase = SESS_IDLE;
	endfunction

	// A request to send opens or restarts a session only when its packet count fits its length.
	function automatic void predict_rts(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] fd);
		int len;
		int pk;
		int win;
		len = int'(fd[23:8]);
		pk  = int'(fd[31:24]);
		if (len == 0 || pk != (len + 6) / 7)
			return;
		sess_peer    = id;
		sess_len     = fd[18:8];
		sess_packets = pk;
		sess_pgn     = fd[63:40];
		win          = effective_window();
		win_first    = 1;
		win_count    = (pk < win) ? pk : win;
		win_got      = 0;
		tick_total   = 0;
		sess_phase   = SESS_WAIT;
		add_result(RK_FRAME, peer_reply_id(), grant_bytes(win_count, win_first), '0, '0, '0);
	endfunction

	// Data packets: in order they become payload writes, out of order they abort a reception.
	function automatic void predict_packet(input logic [DATA_W-1:0] fd);
		int want;
		int cnt;
		int offs;
		int end_pkt;
		int left;
		int win;
		logic [63:0] mask;
		if (sess_phase == SESS_IDLE)
			return;
		want = win_first + win_got;
		if (int'(fd[7:0]) != want) begin
			if (sess_phase == SESS_RECV)
				abort_session();
			return;
		end
		win_got++;
		tick_total = 0;
		sess_phase = SESS_RECV;
		if (want >= sess_packets)
			cnt = int'(sess_len) - (sess_packets - 1) * PKT_BYTES;
		else
			cnt = PKT_BYTES;
		if (cnt > PKT_BYTES)
			cnt = PKT_BYTES;
		mask = (64'd1 << (8 * cnt)) - 64'd1;
		offs = (want - 1) * PKT_BYTES;
		add_result(RK_PAYLOAD, '0, '0, offs[OFFS_W-1:0], fd[63:8] & mask[55:0], cnt[CNT_W-1:0]);
		if (win_got < win_count)
			return;
		end_pkt = win_first + win_count - 1;
		if (end_pkt >= sess_packets) begin
			add_result(RK_DONE, '0, '0, '0, '0, '0);
			add_result(RK_FRAME, peer_reply_id(), {sess_pgn, FILL_BYTE, sess_packets[7:0],
				5'd0, sess_len[10:8], sess_len[7:0], CB_EOM}, '0, '0, '0);
			sess_phase = SESS_IDLE;
		end else begin
			left       = sess_packets - end_pkt;
			win        = effective_window();
			win_first  = (end_pkt + 1) & 8'hFF;
			win_count  = (left < win) ? left : win;
			win_got    = 0;
			sess_phase = SESS_WAIT;
			add_result(RK_FRAME, peer_reply_id(), grant_bytes(win_count, win_first), '0, '0, '0);
		end
	endfunction

	// Ticks count towards the timeout of the current phase and abort once it is reached.
	function automatic void predict_tick();
		int limit;
		if (sess_phase == SESS_WAIT)
			limit = int'(cfg_cts_timeout);
		else if (sess_phase == SESS_RECV)
			limit = int'(cfg_data_timeout);
		else
			return;
		if (tick_total >= limit)
			abort_session();
		else
			tick_total++;
	endfunction

	function automatic void predict_frame(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] fd);
		sess_phase_t phase_before;
		result_t r;
		phase_before = sess_phase;
		step_n = 0;
		case (op)
			OP_TICK: predict_tick();
			OP_CONN: if (fd[7:0] == CB_RTS) predict_rts(id, fd);
			OP_DATA: predict_packet(fd);
			default: ;
		endcase
		for (int i = 0; i < step_n; i++) begin
			r = step_out[i];
			r.last_result = (i == step_n - 1);
			awaited_results.push_back(r);
		end
		if (step_n > 0 || (op == OP_TICK && phase_before != SESS_IDLE))
			counted_items++;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("kind %0d id %h data %h offset %0d bytes %h count %0d pgn %h length %0d last %0b",
			r.kind, r.tx_can_id, r.tx_data, r.payload_offset, r.payload_bytes,
			r.payload_count, r.pgn, r.message_length, r.last_result);
	endfunction

	function automatic void note_failure(input string msg);
		if (failures < MAX_REPORTS)
			$display("%s", msg);
		failures++;
	endfunction

	function automatic void check_result();
		result_t got;
		result_t want;
		got.kind           = result_kind_t'(res_if.result_kind);
		got.tx_can_id      = res_if.tx_can_id;
		got.tx_data        = res_if.tx_data;
		got.payload_offset = res_if.payload_offset;
		got.payload_bytes  = res_if.payload_bytes;
		got.payload_count  = res_if.payload_count;
		got.pgn            = res_if.pgn;
		got.message_length = res_if.message_length;
		got.last_result    = res_if.last_result;
		if (awaited_results.size() == 0) begin
			note_failure($sformatf("Unexpected result: %s", describe(got)));
		end else begin
			want = awaited_results.pop_front();
			if (got.kind !== want.kind || got.tx_can_id !== want.tx_can_id
					|| got.tx_data !== want.tx_data || got.payload_offset !== want.payload_offset
					|| got.payload_bytes !== want.payload_bytes
					|| got.payload_count !== want.payload_count || got.pgn !== want.pgn
					|| got.message_length !== want.message_length
					|| got.last_result !== want.last_result)
				note_failure($sformatf("Result mismatch\n  expected %s\n  actual   %s",
					describe(want), describe(got)));
		end
	endfunction

	// Result receiver: checks each transaction, then stalls at random or for a requested hold-off.
	initial begin
		snk_stall_left = 0;
		snk_hold_left  = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_if.valid && res_if.ready) begin
					check_result();
					snk_stall_left = snk_idle_en ? $urandom_range(0, STALL_MAX) : 0;
				end
				if (hold_request > 0) begin
					snk_hold_left = hold_request;
					hold_request  = 0;
				end
				if (snk_hold_left > 0) begin
					snk_hold_left--;
					res_if.ready <= 1'b0;
				end else if (snk_stall_left > 0) begin
					snk_stall_left--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
				end
			end
		end
	end

	// Offers one frame after a random gap and predicts its results once it is accepted.
	task automatic send_frame(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] fd);
		int gap;
		gap = src_idle_en ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid      <= 1'b1;
		rx_if.operation  <= op;
		rx_if.can_id     <= id;
		rx_if.frame_data <= fd;
		do
			@(posedge clk);
		while (!rx_if.ready);
		predict_frame(op, id, fd);
	endtask

	task automatic send_rts(input int len, input int pk);
		logic [31:0] r;
		r = $urandom;
		send_frame(OP_CONN, rand_id(), rts_bytes(len[15:0], pk[7:0], r[31:8], r[7:0]));
	endtask

	task automatic send_packet(input int seq);
		logic [DATA_W-1:0] fd;
		fd = rand64();
		fd[7:0] = seq[7:0];
		send_frame(OP_DATA, rand_id(), fd);
	endtask

	task automatic send_tick();
		send_frame(OP_TICK, rand_id(), rand64());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			CFG_CTS_WINDOW:   cfg_window = value[7:0];
			CFG_CTS_TIMEOUT:  cfg_cts_timeout = value;
			CFG_DATA_TIMEOUT: cfg_data_timeout = value;
			default: ;
		endcase
	endtask

	// Writes all three registers back to back; only called while the block is idle.
	task automatic configure(input int window, input int cts_to, input int data_to);
		logic [31:0] r;
		r = $urandom;
		write_reg(CFG_CTS_WINDOW, {r[7:0], window[7:0]});
		write_reg(CFG_CTS_TIMEOUT, cts_to[15:0]);
		write_reg(CFG_DATA_TIMEOUT, data_to[15:0]);
		cfg_if.valid <= 1'b0;
	endtask

	// Stops offering, waits for every awaited result, then lets the pipeline drain.
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One session: a valid request, then mostly in-order packets mixed with ticks and,
	// when noisy, stray packets, other control frames, rejected and restarting requests.
	task automatic run_session(input int len_lo, input int len_hi, input bit noisy);
		int len;
		int roll;
		int guard;
		logic [DATA_W-1:0] fd;
		len = $urandom_range(len_lo, len_hi);
		send_rts(len, (len + 6) / 7);
		guard = 0;
		while (sess_phase != SESS_IDLE && guard < 4000) begin
			guard++;
			roll = noisy ? $urandom_range(0, 99) : $urandom_range(0, 89);
			fd = rand64();
			if (roll < 80) begin
				send_packet(win_first + win_got);
			end else if (roll < 90) begin
				send_tick();
			end else if (roll < 93) begin
				repeat ($urandom_range(1, 6)) send_tick();
			end else if (roll < 96) begin
				send_frame(OP_DATA, rand_id(), fd);
			end else if (roll == 96) begin
				send_frame(OP_UNUSED, rand_id(), fd);
			end else if (roll == 97) begin
				fd[7:0] = fd[8] ? CB_CTS : CB_EOM;
				send_frame(OP_CONN, rand_id(), fd);
			end else if (roll == 98) begin
				len = fd[9] ? $urandom_range(0, 65535) : $urandom_range(0, 40);
				send_rts(len, (len + 6) / 7 + 1);
			end else begin
				len = $urandom_range(len_lo, len_hi);
				send_rts(len, (len + 6) / 7);
			end
		end
	endtask

	task automatic run_phase(input int window, input int cts_to, input int data_to,
			input bit src_en, input bit snk_en, input int items, input int len_hi);
		int goal;
		configure(window, cts_to, data_to);
		src_idle_en = src_en;
		snk_idle_en = snk_en;
		goal = counted_items + items;
		while (counted_items < goal)
			run_session(1, len_hi, 1'b1);
		wait_idle();
	endtask

	// Directed frames at the reset settings: ignored frames, rejected and restarted requests,
	// a one-byte message, an abort on a stray packet and a message spanning two windows.
	task automatic test_directed();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		send_frame(OP_TICK, '0, '0);
		send_frame(OP_DATA, '1, {56'hFF_FFFF_FFFF_FFFF, 8'd1});
		send_frame(OP_UNUSED, '1, '1);
		send_frame(OP_CONN, '1, {56'hFF_FFFF_FFFF_FFFF, CB_CTS});
		send_frame(OP_CONN, rand_id(), rts_bytes(16'd0, 8'd0, 24'h123456, FILL_BYTE));
		send_frame(OP_CONN, rand_id(), rts_bytes(16'd10, 8'd3, 24'h00FEDC, FILL_BYTE));
		send_frame(OP_CONN, rand_id(), rts_bytes(16'hFFFF, 8'hFF, 24'hFFFFFF, FILL_BYTE));
		send_frame(OP_CONN, '1, rts_bytes(16'd1785, 8'd255, 24'hFFFFFF, 8'h00));
		send_frame(OP_CONN, '0, rts_bytes(16'd1, 8'd1, 24'h000000, FILL_BYTE));
		send_packet(2);
		send_frame(OP_DATA, '1, {56'hFF_FFFF_FFFF_FFFF, 8'd1});
		send_rts(15, 3);
		send_frame(OP_DATA, '0, {56'd0, 8'd1});
		send_packet(3);
		send_tick();
		send_rts(63, 9);
		for (int seq = 1; seq <= 9; seq++)
			send_packet(seq);
		wait_idle();
	endtask

	// Timeouts while waiting for a packet and between packets, each one tick past its limit.
	task automatic test_timeouts();
		configure(2, 3, 2);
		send_rts(20, 3);
		repeat (4) send_tick();
		send_rts(20, 3);
		send_packet(1);
		repeat (3) send_tick();
		send_tick();
		send_rts(20, 3);
		send_packet(1);
		send_packet(2);
		repeat (3) send_tick();
		send_packet(3);
		wait_idle();
	endtask

	// Random sessions under several register settings, the extremes among them.
	task automatic test_random_settings();
		run_phase(1, 1, 1, 1'b1, 1'b1, 40, 20);
		run_phase(0, $urandom_range(2, 10), $urandom_range(2, 10), 1'b1, 1'b0, 40, 40);
		run_phase($urandom_range(2, 20), $urandom_range(1, 300), $urandom_range(1, 300),
			1'b0, 1'b1, 40, 120);
		run_phase($urandom_range(2, 255), 65535, 1, 1'b1, 1'b1, 40, 60);
	endtask

	// The longest message in one window of the largest size, without idling.
	task automatic test_largest_message();
		configure(255, 65535, 65535);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		run_session(1779, 1785, 1'b0);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while frames keep coming, so the block fills
	// and stalls its input; the sender then pauses until every result has arrived.
	task automatic test_backpressure();
		configure(4, 200, 200);
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_request = 400;
		repeat (3) run_session(8, 40, 1'b0);
		wait_idle();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		hold_request = 150;
		repeat (2) run_session(1, 30, 1'b1);
		wait_idle();
	endtask

	// Stimulus and end of run.
	initial begin
		failures         = 0;
		counted_items    = 0;
		hold_request     = 0;
		src_idle_en      = 1'b0;
		snk_idle_en      = 1'b0;
		cfg_window       = CTS_WINDOW_RST;
		cfg_cts_timeout  = CTS_TIMEOUT_RST;
		cfg_data_timeout = DATA_TIMEOUT_RST;
		sess_phase       = SESS_IDLE;
		sess_peer        = '0;
		sess_len         = '0;
		sess_pgn         = '0;
		sess_packets     = 0;
		win_first        = 0;
		win_count        = 0;
		win_got          = 0;
		tick_total       = 0;
		arst_n           <= 1'b0;
		rx_if.valid      <= 1'b0;
		rx_if.operation  <= OP_TICK;
		rx_if.can_id     <= '0;
		rx_if.frame_data <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= CFG_CTS_WINDOW;
		cfg_if.data      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_timeouts();
		test_random_settings();
		test_largest_message();
		test_backpressure();
		wait_idle();
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
